FILE: src/spdb_pkg.sv
package spdb_pkg;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [2:0] REG_GENERATION = 3'd0;
  localparam logic [2:0] REG_DISP_W     = 3'd1;
  localparam logic [2:0] REG_DISP_H     = 3'd2;
  localparam logic [2:0] REG_ASPECT     = 3'd3;
  localparam logic [2:0] REG_INT_SCALE  = 3'd4;
  localparam logic [2:0] REG_MODE       = 3'd5;
  localparam logic [2:0] REG_PHASE      = 3'd6;

  localparam logic [1:0] PS_RGB565 = 2'd0;
  localparam logic [1:0] PS_RGB888 = 2'd1;

  localparam logic [31:0] UNIT_SCALE   = 32'h0001_0000;
  localparam logic [11:0] PERMILLE_ONE = 12'd1000;
  localparam logic [31:0] FILL_WORD    = 32'hDEAD_BEEF;
  localparam logic [31:0] ALIAS_BITS   = 32'hC000_0000;
  localparam logic [31:0] END_WORD     = 32'h8000_0000;
  localparam logic [31:0] SIZE_FLAG    = 32'h4000_0000;
  localparam logic [31:0] NEW_POS_WORD = 32'h4000_FFF0;
  localparam logic [31:0] CTL_OLD      = 32'h4000_4000;
  localparam logic [31:0] CTL_NEW      = 32'h4000_5800;
  localparam logic [31:0] HEAD_OLD_U   = 32'h0700_0010;
  localparam logic [31:0] HEAD_OLD_S   = 32'h1000_1800;
  localparam logic [31:0] HEAD_NEW_U   = 32'h0800_8000;
  localparam logic [31:0] HEAD_NEW_S   = 32'h1100_0000;

  typedef struct packed {
    logic [11:0] src_width;
    logic [11:0] src_height;
    logic [11:0] crop_x;
    logic [11:0] crop_y;
    logic [11:0] full_width;
    logic [1:0]  pixel_size;
    logic [31:0] buffer_address;
    logic [31:0] kernel_word;
  } req_t;

  typedef struct packed {
    logic [31:0] list_word;
    logic [9:0]  word_index;
    logic        last_word;
  } res_t;

  typedef struct packed {
    logic        generation;
    logic [11:0] display_width;
    logic [11:0] display_height;
    logic [11:0] aspect_permille;
    logic        integer_scale;
    logic [1:0]  scaler_mode;
    logic [7:0]  scaler_phase;
  } cfg_t;

  typedef struct packed {
    logic        gen;
    logic        unity;
    logic [2:0]  fmt;
    logic [13:0] ox;
    logic [13:0] oy;
    logic [15:0] cw;
    logic [15:0] ch;
    logic [11:0] sw;
    logic [11:0] sh;
    logic [31:0] start;
    logic [13:0] pitch;
    logic [23:0] sx;
    logic [23:0] sy;
    logic [1:0]  mode;
    logic [7:0]  phase;
    logic [31:0] kern;
  } job_t;

  function automatic logic [25:0] times_bytes(input logic [25:0] x, input logic [1:0] ps);
    logic [25:0] r;
    case (ps)
      PS_RGB565: r = {x[24:0], 1'b0};
      PS_RGB888: r = {x[24:0], 1'b0} + x;
      default:   r = {x[23:0], 2'b00};
    endcase
    return r;
  endfunction

endpackage

FILE: src/spdb_front.sv
module spdb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  spdb_pkg::req_t req_i,
  input  spdb_pkg::cfg_t cfg_i,
  output logic           busy_o,
  output logic           push_o,
  output spdb_pkg::job_t job_o,
  input  logic           full_i
);
  import spdb_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL1   = 4'd1;
  localparam logic [3:0] ST_D_SA   = 4'd2;
  localparam logic [3:0] ST_D_SX   = 4'd3;
  localparam logic [3:0] ST_D_SY   = 4'd4;
  localparam logic [3:0] ST_D_T    = 4'd5;
  localparam logic [3:0] ST_D_Q    = 4'd6;
  localparam logic [3:0] ST_D_S    = 4'd7;
  localparam logic [3:0] ST_MUL2   = 4'd8;
  localparam logic [3:0] ST_D_SX2  = 4'd9;
  localparam logic [3:0] ST_D_CW   = 4'd10;
  localparam logic [3:0] ST_D_CH   = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  // ceil(2^33 / 1000): (x * RECIP_1000) >> 33 equals x / 1000 for any x below 2^24
  localparam logic [23:0] RECIP_1000 = 24'h83126F;

  logic [3:0]  state_q, state_d;
  req_t        req_q;
  cfg_t        cfg_q;
  logic        unity_q;
  logic [23:0] p_sa_q, p_cf_q;
  logic [31:0] d1_q, sx_q, sy_q, scale_q, cw_q, ch_q;
  logic [47:0] sa_prod;

  // shared restoring divider, one quotient bit per cycle
  logic        div_act_q, div_done_q;
  logic [4:0]  div_cnt_q;
  logic [31:0] num_q, den_q, rem_q;
  logic [31:0] div_n, div_d;
  logic [32:0] rem_sh, rem_sub;
  logic        div_state;

  logic [31:0] sh16, sw16, dw32, dh32;
  logic [31:0] dx, dy, start_w;
  logic [25:0] cx_b, cf_b, fw_b;
  logic        unity_now;

  assign sh16 = {4'b0, req_q.src_height, 16'b0};
  assign sw16 = {4'b0, req_q.src_width, 16'b0};
  assign dw32 = {20'b0, cfg_q.display_width};
  assign dh32 = {20'b0, cfg_q.display_height};

  assign sa_prod = {24'b0, p_sa_q} * {24'b0, RECIP_1000};

  always_comb begin
    div_n = UNIT_SCALE;
    div_d = scale_q;
    div_state = 1'b1;
    case (state_q)
      ST_D_SX:  begin div_n = {d1_q[15:0], 16'b0}; div_d = dw32; end
      ST_D_SY:  begin div_n = sh16; div_d = dh32; end
      ST_D_T:   begin div_n = sh16; div_d = sx_q; end
      ST_D_Q:   begin div_n = UNIT_SCALE; div_d = scale_q; end
      ST_D_S:   begin div_n = UNIT_SCALE; div_d = scale_q; end
      ST_D_SX2: begin div_n = d1_q; div_d = {20'b0, cfg_q.aspect_permille}; end
      ST_D_CW:  begin div_n = sw16; div_d = sx_q; end
      ST_D_CH:  begin div_n = sh16; div_d = sy_q; end
      default:  div_state = 1'b0;
    endcase
  end

  assign rem_sh  = {rem_q, num_q[31]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_act_q  <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_act_q) begin
      div_cnt_q <= div_cnt_q + 5'd1;
      if (div_cnt_q == 5'd31) begin
        div_act_q  <= 1'b0;
        div_done_q <= 1'b1;
      end
    end else if (div_done_q) begin
      div_done_q <= 1'b0;
    end else if (div_state) begin
      div_act_q <= 1'b1;
      div_cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_act_q) begin
      if (!rem_sub[32]) begin
        rem_q <= rem_sub[31:0];
      end else begin
        rem_q <= rem_sh[31:0];
      end
      num_q <= {num_q[30:0], ~rem_sub[32]};
    end else if (!div_done_q && div_state) begin
      num_q <= div_n;
      den_q <= div_d;
      rem_q <= '0;
    end
  end

  assign unity_now = (req_q.src_width == cfg_q.display_width) &&
                     (req_q.src_height == cfg_q.display_height) &&
                     (cfg_q.aspect_permille == PERMILLE_ONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_MUL1;
      ST_MUL1:  state_d = unity_now ? ST_FIN : ST_D_SA;
      ST_D_SA:  state_d = ST_D_SX;
      ST_D_SX:  if (div_done_q) state_d = ST_D_SY;
      ST_D_SY:  if (div_done_q) state_d = ST_D_T;
      ST_D_T:   if (div_done_q) state_d = cfg_q.integer_scale ? ST_D_Q : ST_MUL2;
      ST_D_Q:   if (div_done_q) state_d = (num_q == '0) ? ST_MUL2 : ST_D_S;
      ST_D_S:   if (div_done_q) state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_D_SX2;
      ST_D_SX2: if (div_done_q) state_d = ST_D_CW;
      ST_D_CW:  if (div_done_q) state_d = ST_D_CH;
      ST_D_CH:  if (div_done_q) state_d = ST_FIN;
      ST_FIN:   if (!full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (start_i) begin
        req_q <= req_i;
        cfg_q <= cfg_i;
      end
      ST_MUL1: begin
        unity_q <= unity_now;
        p_sa_q  <= req_q.src_width * cfg_q.aspect_permille;
        p_cf_q  <= req_q.crop_y * req_q.full_width;
        cw_q    <= '0;
        ch_q    <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
      end
      ST_D_SA:  d1_q <= {17'b0, sa_prod[47:33]};
      ST_D_SX:  if (div_done_q) sx_q <= num_q;
      ST_D_SY:  if (div_done_q) sy_q <= num_q;
      ST_D_T:   if (div_done_q) scale_q <= (num_q > dh32) ? sy_q : sx_q;
      // hold the integer ratio in scale_q until the snap division
      ST_D_Q:   if (div_done_q) scale_q <= (num_q == '0) ? UNIT_SCALE : num_q;
      ST_D_S:   if (div_done_q) scale_q <= num_q;
      ST_MUL2:  d1_q <= scale_q * 32'(PERMILLE_ONE);
      ST_D_SX2: if (div_done_q) begin
        sx_q <= num_q;
        sy_q <= scale_q;
      end
      ST_D_CW:  if (div_done_q) cw_q <= num_q;
      ST_D_CH:  if (div_done_q) ch_q <= num_q;
      default: ;
    endcase
  end

  assign dx   = dw32 - cw_q;
  assign dy   = dh32 - ch_q;
  assign cx_b = times_bytes({14'b0, req_q.crop_x}, req_q.pixel_size);
  assign cf_b = times_bytes({2'b0, p_cf_q}, req_q.pixel_size);
  assign fw_b = times_bytes({14'b0, req_q.full_width}, req_q.pixel_size);
  assign start_w = req_q.buffer_address + {6'b0, cx_b} + {6'b0, cf_b};

  always_comb begin
    job_o.gen   = cfg_q.generation;
    job_o.unity = unity_q;
    case (req_q.pixel_size)
      PS_RGB565: job_o.fmt = 3'd4;
      PS_RGB888: job_o.fmt = 3'd5;
      default:   job_o.fmt = 3'd0;
    endcase
    job_o.ox    = unity_q ? '0 : dx[14:1];
    job_o.oy    = unity_q ? '0 : dy[14:1];
    job_o.cw    = cw_q[15:0];
    job_o.ch    = ch_q[15:0];
    job_o.sw    = req_q.src_width;
    job_o.sh    = req_q.src_height;
    job_o.start = start_w;
    job_o.pitch = fw_b[13:0];
    job_o.sx    = sx_q[23:0];
    job_o.sy    = sy_q[23:0];
    job_o.mode  = cfg_q.scaler_mode;
    job_o.phase = cfg_q.scaler_phase;
    job_o.kern  = req_q.kernel_word;
  end

  assign push_o = (state_q == ST_FIN) && !full_i;
  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: src/spdb_fifo.sv
module spdb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spdb_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output spdb_pkg::job_t job_o
);
  import spdb_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  assign job_o   = mem_q[rptr_q];
  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);

endmodule

FILE: src/spdb_back.sv
module spdb_back #(
  parameter int unsigned LIST_TOP = 768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  spdb_pkg::job_t job_i,
  output logic           pop_o,
  output logic           valid_o,
  output spdb_pkg::res_t res_o
);
  import spdb_pkg::*;

  localparam logic [9:0] TOP = LIST_TOP[9:0];

  job_t        job_q;
  logic        act_q;
  logic [4:0]  k_q;
  logic [4:0]  n, h, j;
  logic [31:0] ctl, head, pos0, pos1, pos2, scw_x, scw_y, word;
  logic        last;
  logic        valid_q;
  res_t        res_q;

  always_comb begin
    ctl  = (job_q.gen ? CTL_NEW : CTL_OLD) | {29'b0, job_q.fmt};
    pos1 = {job_q.ch, job_q.cw};
    pos2 = {4'b0, job_q.sh, 4'b0, job_q.sw};
    if (job_q.gen) begin
      pos0 = {2'b0, job_q.oy[13], 1'b0, job_q.oy[11:0],
              2'b0, job_q.ox[13], 1'b0, job_q.ox[11:0]};
    end else begin
      pos0 = {8'hFF, job_q.oy[11:0], job_q.ox[11:0]};
    end
    scw_x = {job_q.sx[23:22] | job_q.mode, job_q.sx[21:0], job_q.phase};
    scw_y = {job_q.sy[23:22] | job_q.mode, job_q.sy[21:0], job_q.phase};
    case ({job_q.gen, job_q.unity})
      2'b01:   begin h = 5'd3; head = ctl | HEAD_OLD_U; end
      2'b00:   begin h = 5'd4; head = ctl | HEAD_OLD_S; end
      2'b11:   begin h = 5'd4; head = ctl | HEAD_NEW_U; end
      default: begin h = 5'd5; head = ctl | HEAD_NEW_S; end
    endcase
    n    = h + (job_q.unity ? 5'd5 : 5'd13);
    j    = k_q - h;
    last = (k_q == n - 5'd1);
    word = '0;
    if (last) begin
      word = END_WORD;
    end else if (k_q < h) begin
      case ({job_q.gen, job_q.unity, k_q[2:0]})
        5'b00_000, 5'b01_000, 5'b10_000, 5'b11_000: word = head;
        5'b00_001, 5'b01_001, 5'b10_001, 5'b11_001: word = pos0;
        5'b01_010: word = pos2 | SIZE_FLAG;
        5'b00_010: word = pos1;
        5'b00_011: word = pos2 | SIZE_FLAG;
        5'b10_010, 5'b11_010: word = NEW_POS_WORD;
        5'b11_011: word = pos2;
        5'b10_011: word = pos1;
        5'b10_100: word = pos2;
        default:   word = '0;
      endcase
    end else begin
      case (j)
        5'd0, 5'd2: word = FILL_WORD;
        5'd1:       word = ALIAS_BITS | job_q.start;
        5'd3:       word = {18'b0, job_q.pitch};
        5'd5:       word = scw_x;
        5'd6:       word = scw_y;
        5'd8, 5'd9, 5'd10, 5'd11: word = job_q.kern;
        default:    word = '0;
      endcase
    end
  end

  assign pop_o = !act_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= act_q;
      if (pop_o) begin
        act_q <= 1'b1;
        k_q   <= '0;
      end else if (act_q) begin
        k_q <= k_q + 5'd1;
        // drop out after the end-of-list word
        if (last) act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    res_q.list_word  <= word;
    res_q.word_index <= TOP - {5'b0, n} + {5'b0, k_q};
    res_q.last_word  <= last;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.last_word |=> valid_q)
    else $error("word stream broken before end of list");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.last_word |=> res_q.word_index == $past(res_q.word_index) + 10'd1)
    else $error("word index did not advance");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.last_word |-> res_q.word_index == TOP - 10'd1)
    else $error("list does not end below the top");

endmodule

FILE: src/scaled_plane_descriptor_builder_core.sv
// channel  | direction | handshake                    | payload
// request  | in        | start high, busy low         | req_i (spdb_pkg::req_t)
// result   | out       | result_valid_o, one cycle    | res_o (spdb_pkg::res_t)
// config   | in/out    | APB write psel&penable&pwrite | paddr, pwdata, prdata
// After a unity request is taken busy stays high through ST_MUL1 and ST_FIN; after a
// scaled one through six divisions (seven or eight when snapping) on the single
// shared divider plus the four steps ST_MUL1, ST_D_SA, ST_MUL2 and ST_FIN.
// The back emits 8, 9, 17 or 18 words on consecutive cycles and idles between lists.
// A two-entry queue lets the front take the next request while words still go out;
// the front holds its finished job in its last step while the queue is full.
// Reset is asynchronous, active low; config registers return to their listed values.
// The result receiver cannot stall; words are never held.
module scaled_plane_descriptor_builder_core #(
  parameter int unsigned LIST_TOP = 768
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  spdb_pkg::req_t              req_i,
  output logic                        result_valid_o,
  output spdb_pkg::res_t              res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spdb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import spdb_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       push, full, pop, empty;
  job_t       job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.generation      <= 1'b0;
      cfg_q.display_width   <= 12'd1920;
      cfg_q.display_height  <= 12'd1080;
      cfg_q.aspect_permille <= PERMILLE_ONE;
      cfg_q.integer_scale   <= 1'b0;
      cfg_q.scaler_mode     <= 2'd0;
      cfg_q.scaler_phase    <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GENERATION: cfg_q.generation      <= pwdata[0];
        REG_DISP_W:     cfg_q.display_width   <= pwdata[11:0];
        REG_DISP_H:     cfg_q.display_height  <= pwdata[11:0];
        REG_ASPECT:     cfg_q.aspect_permille <= pwdata[11:0];
        REG_INT_SCALE:  cfg_q.integer_scale   <= pwdata[0];
        REG_MODE:       cfg_q.scaler_mode     <= pwdata[1:0];
        REG_PHASE:      cfg_q.scaler_phase    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GENERATION: prdata = {31'b0, cfg_q.generation};
      REG_DISP_W:     prdata = {20'b0, cfg_q.display_width};
      REG_DISP_H:     prdata = {20'b0, cfg_q.display_height};
      REG_ASPECT:     prdata = {20'b0, cfg_q.aspect_permille};
      REG_INT_SCALE:  prdata = {31'b0, cfg_q.integer_scale};
      REG_MODE:       prdata = {30'b0, cfg_q.scaler_mode};
      REG_PHASE:      prdata = {24'b0, cfg_q.scaler_phase};
      default:        prdata = '0;
    endcase
  end

  spdb_front u_front (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .req_i,
    .cfg_i   (cfg_q),
    .busy_o  (busy),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full)
  );

  spdb_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  spdb_back #(
    .LIST_TOP (LIST_TOP)
  ) u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .valid_o (result_valid_o),
    .res_o
  );

endmodule

FILE: tb/sv/scaled_plane_descriptor_builder_core_tb.sv
module scaled_plane_descriptor_builder_core_tb;
  import spdb_pkg::*;

  localparam int unsigned LIST_TOP   = 768;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT = 400;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                result_valid_o;
  res_t                res_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  scaled_plane_descriptor_builder_core #(.LIST_TOP(LIST_TOP)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .result_valid_o(result_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the register file
  cfg_t cfg;

  res_t        word_q[$];
  int unsigned mismatches;
  int unsigned words_seen;
  int unsigned reqs_sent;
  int unsigned unity_reqs;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  logic [31:0] head_word;

  typedef struct {
    req_t        req;
    bit          has_first;
    logic [31:0] first_word;
  } row_t;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] div32(input logic [31:0] n, input logic [31:0] d);
    if (d == 32'd0) return 32'hFFFF_FFFF;
    return n / d;
  endfunction

  // build the descriptor words for one request and queue them
  task automatic build_descriptor(input req_t r);
    logic [31:0] sw, sh, cx, cy, fw, bytes, fmt, strt, pitch, ctl, pos0, pos1, pos2;
    logic [31:0] scw_x, scw_y, scale, q, dw, dh, asp;
    logic [31:0] sx, sy, cw, ch, ox, oy;
    logic [31:0] w[$];
    bit          unity;
    res_t        e;
    sw = r.src_width; sh = r.src_height; cx = r.crop_x; cy = r.crop_y;
    fw = r.full_width;
    dw = cfg.display_width; dh = cfg.display_height; asp = cfg.aspect_permille;
    sx = 0; sy = 0; cw = 0; ch = 0; ox = 0; oy = 0;
    case (r.pixel_size)
      PS_RGB565: begin bytes = 2; fmt = 4; end
      PS_RGB888: begin bytes = 3; fmt = 5; end
      default:   begin bytes = 4; fmt = 0; end
    endcase
    unity = (sw == dw) && (sh == dh) && (asp == 32'd1000);
    if (!unity) begin
      sx = div32(32'h10000 * div32(sw * asp, 32'd1000), dw);
      sy = div32(32'h10000 * sh, dh);
      scale = (div32(32'h10000 * sh, sx) > dh) ? sy : sx;
      if (cfg.integer_scale) begin
        q = div32(32'h10000, scale);
        scale = (q == 0) ? 32'h10000 : 32'h10000 / q;
      end
      sx = div32(scale * 32'd1000, asp);
      sy = scale;
      cw = div32(32'h10000 * sw, sx);
      ch = div32(32'h10000 * sh, sy);
      ox = (dw - cw) >> 1;
      oy = (dh - ch) >> 1;
    end else begin
      unity_reqs++;
    end
    strt  = r.buffer_address + cx * bytes + cy * fw * bytes;
    pitch = fw * bytes;
    pos1  = {ch[15:0], cw[15:0]};
    pos2  = {sh[15:0], sw[15:0]};
    scw_x = (sx << 8) | (32'(cfg.scaler_mode) << 30) | 32'(cfg.scaler_phase);
    scw_y = (sy << 8) | (32'(cfg.scaler_mode) << 30) | 32'(cfg.scaler_phase);
    if (!cfg.generation) begin
      ctl  = 32'h4000_0000 | (32'd2 << 13) | fmt;
      pos0 = (ox & 32'hFFF) | ((oy & 32'hFFF) << 12) | 32'hFF00_0000;
      if (unity) begin
        w.push_back(ctl | (32'd7 << 24) | 32'h10);
        w.push_back(pos0);
        w.push_back(pos2 | 32'h4000_0000);
      end else begin
        w.push_back(ctl | (32'd16 << 24) | 32'h1800);
        w.push_back(pos0);
        w.push_back(pos1);
        w.push_back(pos2 | 32'h4000_0000);
      end
    end else begin
      ctl  = 32'h4000_0000 | (32'd1 << 12) | (32'd1 << 11) | (32'd2 << 13) | fmt;
      pos0 = (ox & 32'h2FFF) | ((oy & 32'h2FFF) << 16);
      if (unity) begin
        w.push_back(ctl | (32'd8 << 24) | (32'd1 << 15));
        w.push_back(pos0);
        w.push_back(32'h4000_FFF0);
        w.push_back(pos2);
      end else begin
        w.push_back(ctl | (32'd17 << 24));
        w.push_back(pos0);
        w.push_back(32'h4000_FFF0);
        w.push_back(pos1);
        w.push_back(pos2);
      end
    end
    w.push_back(32'hDEAD_BEEF);
    w.push_back(32'hC000_0000 | strt);
    w.push_back(32'hDEAD_BEEF);
    w.push_back(pitch);
    if (!unity) begin
      w.push_back(32'd0);
      w.push_back(scw_x);
      w.push_back(scw_y);
      w.push_back(32'd0);
      repeat (4) w.push_back(r.kernel_word);
    end
    w.push_back(32'h8000_0000);
    head_word = w[0];
    foreach (w[k]) begin
      e.list_word  = w[k];
      e.word_index = 10'(LIST_TOP - w.size() + k);
      e.last_word  = (k == w.size() - 1);
      word_q.push_back(e);
    end
  endtask

  // compare every emitted word with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      words_seen++;
      if (word_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h idx %0d", res_o.list_word,
                                       res_o.word_index);
      end else begin
        res_t e;
        e = word_q.pop_front();
        if (e.list_word !== res_o.list_word || e.word_index !== res_o.word_index ||
            e.last_word !== res_o.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp %h/%0d/%b got %h/%0d/%b", e.list_word,
                     e.word_index, e.last_word, res_o.list_word, res_o.word_index,
                     res_o.last_word);
        end
      end
    end
  end

  // watchdog: count cycles with no handshake
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GENERATION: cfg.generation      = val[0];
      REG_DISP_W:     cfg.display_width   = val[11:0];
      REG_DISP_H:     cfg.display_height  = val[11:0];
      REG_ASPECT:     cfg.aspect_permille = val[11:0];
      REG_INT_SCALE:  cfg.integer_scale   = val[0];
      REG_MODE:       cfg.scaler_mode     = val[1:0];
      default:        cfg.scaler_phase    = val[7:0];
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    reg_write(REG_GENERATION, 32'(c.generation));
    reg_write(REG_DISP_W, 32'(c.display_width));
    reg_write(REG_DISP_H, 32'(c.display_height));
    reg_write(REG_ASPECT, 32'(c.aspect_permille));
    reg_write(REG_INT_SCALE, 32'(c.integer_scale));
    reg_write(REG_MODE, 32'(c.scaler_mode));
    reg_write(REG_PHASE, 32'(c.scaler_phase));
  endtask

  // hold until all words are out, then let the divider finish
  task automatic wait_drained();
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // send one request; start stays high across back-to-back requests
  task automatic send_req(input req_t r, input bit keep);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    build_descriptor(r);
    reqs_sent++;
    if (!keep) start <= 1'b0;
  endtask

  task automatic send_paced(input req_t r);
    bit gap;
    gap = ($urandom_range(99) < send_idle_pct);
    send_req(r, !gap);
    if (gap) repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  function automatic req_t rand_req(input bit match);
    req_t r;
    r.src_width      = match ? cfg.display_width  : 12'($urandom_range(1, 4095));
    r.src_height     = match ? cfg.display_height : 12'($urandom_range(1, 4095));
    if (!match && $urandom_range(3) == 0) begin
      r.src_width  = 12'($urandom_range(1, 64));
      r.src_height = 12'($urandom_range(1, 64));
    end
    r.crop_x         = 12'($urandom);
    r.crop_y         = 12'($urandom);
    r.full_width     = 12'($urandom_range(1, 4095));
    r.pixel_size     = 2'($urandom);
    r.buffer_address = $urandom;
    r.kernel_word    = $urandom;
    return r;
  endfunction

  function automatic req_t mk(input int w, input int h, input int cx, input int cy,
                              input int fw, input int ps, input logic [31:0] ba,
                              input logic [31:0] kw);
    req_t r;
    r.src_width = 12'(w); r.src_height = 12'(h); r.crop_x = 12'(cx);
    r.crop_y = 12'(cy); r.full_width = 12'(fw); r.pixel_size = 2'(ps);
    r.buffer_address = ba; r.kernel_word = kw;
    return r;
  endfunction

  row_t   rows[$];
  cfg_t   c;
  row_t   rw;
  int     phase;

  initial begin
    rst_ni = 1'b0; start = 1'b0; req_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; words_seen = 0; reqs_sent = 0; unity_reqs = 0; idle_cycles = 0;
    send_idle_pct = 0;
    cfg = '{generation: 1'b0, display_width: 12'd1920, display_height: 12'd1080,
            aspect_permille: 12'd1000, integer_scale: 1'b0, scaler_mode: 2'd0,
            scaler_phase: 8'd0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: header word typed in where obvious
    rows.push_back('{mk(1920, 1080, 0, 0, 1920, 0, 32'h0, 32'h0), 1, 32'h4700_4014});
    rows.push_back('{mk(1920, 1080, 4095, 4095, 4095, 1, '1, '1), 1, 32'h4700_4015});
    rows.push_back('{mk(1920, 1080, 7, 3, 2000, 2, 32'h1000, 32'h5), 1, 32'h4700_4010});
    rows.push_back('{mk(1920, 1080, 1, 1, 1, 3, 32'h8000_0000, 32'h1), 1, 32'h4700_4010});
    rows.push_back('{mk(1, 1, 0, 0, 1, 0, 32'h0, 32'hAAAA_5555), 1, 32'h5000_5804});
    rows.push_back('{mk(4095, 4095, 4095, 4095, 4095, 2, '1, '1), 1, 32'h5000_5800});
    rows.push_back('{mk(640, 480, 10, 20, 640, 1, 32'h2000_0000, 32'h5555_AAAA), 0, 0});
    rows.push_back('{mk(320, 240, 0, 0, 320, 0, 32'h0, 32'h1234_5678), 0, 0});
    rows.push_back('{mk(1920, 1000, 0, 0, 1920, 2, 32'h0, 32'h0), 0, 0});
    rows.push_back('{mk(4095, 1, 0, 0, 4095, 3, 32'hFFFF_0000, 32'h0), 0, 0});
    foreach (rows[i]) begin
      send_req(rows[i].req, i != rows.size() - 1);
      if (rows[i].has_first && head_word !== rows[i].first_word) begin
        mismatches++;
        if (mismatches <= 10) $display("header row %0d: table %h model %h", i,
                                       rows[i].first_word, head_word);
      end
    end
    wait_drained();

    // extremes: newer layout, odd screens, snapping, smallest aspect
    c = '{1'b1, 12'd4095, 12'd1, 12'd4000, 1'b1, 2'd3, 8'd255};
    write_all(c);
    send_req(mk(4095, 1, 5, 5, 4095, 1, '1, 32'hF0F0_F0F0), 1'b1);
    send_req(mk(1, 4095, 0, 0, 1, 0, 32'h0, 32'h0F0F_0F0F), 1'b1);
    send_req(mk(100, 100, 1, 2, 100, 2, 32'h10, 32'h3), 1'b0);
    wait_drained();
    c = '{1'b1, 12'd1, 12'd4095, 12'd1, 1'b0, 2'd1, 8'd1};
    write_all(c);
    send_req(mk(1, 4095, 0, 0, 1, 2, 32'h0, 32'h0), 1'b1);
    send_req(mk(2048, 2048, 0, 0, 2048, 1, 32'h0, 32'h9), 1'b0);
    wait_drained();
    reg_write(REG_ASPECT, 32'd1000);
    send_req(mk(1, 4095, 3, 3, 9, 0, 32'h44, 32'h0), 1'b1);
    send_req(mk(4095, 4095, 0, 0, 4095, 0, 32'h44, 32'h0), 1'b0);
    wait_drained();

    // random phases with different configurations and pacing
    for (phase = 0; phase < 6; phase++) begin
      c.generation      = phase[0];
      c.display_width   = (phase == 5) ? 12'd4095 : 12'($urandom_range(1, 4095));
      c.display_height  = (phase == 5) ? 12'd4095 : 12'($urandom_range(1, 4095));
      c.aspect_permille = (phase < 2) ? 12'd1000 : 12'($urandom_range(1, 4000));
      c.integer_scale   = phase[1];
      c.scaler_mode     = 2'($urandom);
      c.scaler_phase    = 8'($urandom);
      write_all(c);
      send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 87 : 0;
      repeat (35) send_paced(rand_req($urandom_range(4) == 0));
      start <= 1'b0;
      wait_drained();
    end

    $display("covered %0d requests (%0d unity), %0d words, reset, directed and six random configurations",
             reqs_sent, unity_reqs, words_seen);
    if (mismatches == 0 && word_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, word_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/spdb_pkg.sv
src/spdb_front.sv
src/spdb_fifo.sv
src/spdb_back.sv
src/scaled_plane_descriptor_builder_core.sv
tb/sv/scaled_plane_descriptor_builder_core_tb.sv
